@@ hdl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the seam cost accumulator and tracer.
// ----------------------------------------------------------------------------
package scd_pkg;

  // default sizes
  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_MAX_HEIGHT  = 64;
  localparam int DEF_ENERGY_BITS = 16;

  // port field widths
  localparam int ENERGY_FIELD_W = 16;
  localparam int SEAM_COL_W     = 8;
  localparam int SEAM_ROW_W     = 6;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 16;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;
  localparam int WIDTH_REG_W = 9;
  localparam int HEIGHT_REG_W = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD1  = 8'b0000_0010,
    S_COMP = 8'b0000_0100,
    S_EMIT = 8'b0000_1000,
    S_TL   = 8'b0001_0000,
    S_TM   = 8'b0010_0000,
    S_TR   = 8'b0100_0000,
    S_TSEL = 8'b1000_0000
  } seq_state_t;

endpackage

@@ hdl/seam_cost_dp_and_trace.sv @@
// ----------------------------------------------------------------------------
// seam_cost_dp_and_trace
// Cumulative seam cost accumulation with vertical seam trace back.
// ----------------------------------------------------------------------------
// Usage:
// - slave stream (s_tvalid/s_tready/s_tdata) carries pixel energies, bottom row
//   first, left to right; one transaction per pixel
// - master stream (m_tvalid/m_tready/m_tdata/m_tlast) carries the seam, one
//   transaction per row, top row first; m_tlast marks the bottom row
// - cfg_we/cfg_index/cfg_data write image width (index 0) and height (index 1);
//   any such write restarts the frame; write only while the block is idle
// Timing:
// - a pixel passes S_IDLE and S_COMP (with S_RD1 between for the first pixel
//   of each row above the bottom one); the cost store has one read port, and
//   a sliding window of three costs from the row below needs only one new read
//   per pixel; the top row's last pixel starts the trace: per row three reads
//   from the cost store, one select, one output load, plus any output stall
// - s_tready is low while a pixel or the trace is in progress, and in any
//   cycle with cfg_we high
// Reset: synchronous; width and height return to their maximum, the frame
// restarts, and the cost store is not cleared (entries are written before read)
// Stall: a result waits in the output register; the trace pauses until taken
// ----------------------------------------------------------------------------
module seam_cost_dp_and_trace
  import scd_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int ENERGY_BITS = DEF_ENERGY_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // slave stream, tdata: pixel_energy[15:0]
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // master stream, tdata: seam_column[7:0], seam_row[13:8], zero fill [15:14]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // seam_last
  output logic                   m_tlast,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int AW     = RW + CW;
  localparam int COST_W = ENERGY_BITS + RW;
  localparam int EUSE   = (ENERGY_BITS < ENERGY_FIELD_W) ? ENERGY_BITS : ENERGY_FIELD_W;

  seq_state_t        state;
  logic [CW-1:0]     wlast;
  logic [RW-1:0]     hlast;
  logic [CW-1:0]     col;
  logic [RW-1:0]     row;
  logic [COST_W-1:0] best_cost;
  logic [CW-1:0]     best_col;
  logic [EUSE-1:0]   energy;
  logic [COST_W-1:0] win_l;
  logic [COST_W-1:0] win_m;
  logic [COST_W-1:0] win_r;
  logic [COST_W-1:0] tr_l;
  logic [COST_W-1:0] tr_m;
  logic [CW-1:0]     tcol;
  logic [RW-1:0]     trow;

  logic [AW-1:0]     rd_addr;
  logic [COST_W-1:0] rd_data;
  logic              wr_en;
  logic [COST_W-1:0] below_min;
  logic [COST_W-1:0] cost;
  logic              top_hit;
  logic              out_free;
  logic [CW-1:0]     wlast_next;
  logic [RW-1:0]     hlast_next;
  logic              go_left;
  logic              go_right;

  assign s_tready = (state == S_IDLE) && !cfg_we;
  assign out_free = !m_tvalid || m_tready;
  assign wr_en    = (state == S_COMP);

  // clamp the register values into the supported range
  always_comb begin
    if (cfg_data[WIDTH_REG_W-1:0] < WIDTH_REG_W'(2)) begin
      wlast_next = CW'(1);
    end else if (32'(cfg_data[WIDTH_REG_W-1:0]) > MAX_WIDTH) begin
      wlast_next = CW'(MAX_WIDTH - 1);
    end else begin
      wlast_next = CW'(cfg_data[WIDTH_REG_W-1:0] - WIDTH_REG_W'(1));
    end
    if (cfg_data[HEIGHT_REG_W-1:0] < HEIGHT_REG_W'(2)) begin
      hlast_next = RW'(1);
    end else if (32'(cfg_data[HEIGHT_REG_W-1:0]) > MAX_HEIGHT) begin
      hlast_next = RW'(MAX_HEIGHT - 1);
    end else begin
      hlast_next = RW'(cfg_data[HEIGHT_REG_W-1:0] - HEIGHT_REG_W'(1));
    end
  end

  // read address for the cost store
  always_comb begin
    case (state)
      S_IDLE:  rd_addr = {row + RW'(1), (col == '0) ? CW'(0) : col + CW'(1)};
      S_RD1:   rd_addr = {row + RW'(1), CW'(1)};
      S_TL:    rd_addr = {trow, tcol - CW'(1)};
      S_TM:    rd_addr = {trow, tcol};
      S_TR:    rd_addr = {trow, tcol + CW'(1)};
      default: rd_addr = '0;
    endcase
  end

  // minimum over the window from the row below, edges clipped
  always_comb begin
    below_min = win_m;
    if (col != '0 && win_l < below_min) begin
      below_min = win_l;
    end
    if (col != wlast && rd_data < below_min) begin
      below_min = rd_data;
    end
    cost = COST_W'(energy) + ((row == hlast) ? '0 : below_min);
    top_hit = (row == '0) && ((col == '0) || (cost <= best_cost));
  end

  // trace step: ties go left, then right, then middle
  always_comb begin
    go_left  = 1'b0;
    go_right = 1'b0;
    if (tcol != '0 && tcol != wlast) begin
      if (tr_l <= tr_m && tr_l <= rd_data) begin
        go_left = 1'b1;
      end else if (rd_data <= tr_m) begin
        go_right = 1'b1;
      end
    end else if (tcol != '0) begin
      go_left = (tr_l <= tr_m);
    end else begin
      go_right = (rd_data <= tr_m);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wlast     <= CW'(MAX_WIDTH - 1);
      hlast     <= RW'(MAX_HEIGHT - 1);
      col       <= '0;
      row       <= RW'(MAX_HEIGHT - 1);
      best_cost <= '1;
      best_col  <= '0;
      tcol      <= '0;
      trow      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // result taken; the emit state reloads the register itself
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          // register writes restart the frame
          if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
            wlast     <= wlast_next;
            col       <= '0;
            row       <= hlast;
            best_cost <= '1;
            best_col  <= '0;
          end else if (cfg_we && cfg_index == REG_IMAGE_HEIGHT) begin
            hlast     <= hlast_next;
            col       <= '0;
            row       <= hlast_next;
            best_cost <= '1;
            best_col  <= '0;
          end else if (s_tvalid && s_tready) begin
            if (row == hlast || col != '0) begin
              state <= S_COMP;
            end else begin
              state <= S_RD1;
            end
          end
        end
        S_RD1: begin
          state <= S_COMP;
        end
        S_COMP: begin
          if (top_hit) begin
            best_cost <= cost;
            best_col  <= col;
          end
          if (row == '0 && col == wlast) begin
            tcol  <= top_hit ? col : best_col;
            trow  <= '0;
            state <= S_EMIT;
          end else begin
            if (col == wlast) begin
              col <= '0;
              row <= row - RW'(1);
            end else begin
              col <= col + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            if (trow == hlast) begin
              col       <= '0;
              row       <= hlast;
              best_cost <= '1;
              best_col  <= '0;
              state     <= S_IDLE;
            end else begin
              trow  <= trow + RW'(1);
              state <= S_TL;
            end
          end
        end
        S_TL: begin
          state <= S_TM;
        end
        S_TM: begin
          state <= S_TR;
        end
        S_TR: begin
          state <= S_TSEL;
        end
        S_TSEL: begin
          if (go_left) begin
            tcol <= tcol - CW'(1);
          end else if (go_right) begin
            tcol <= tcol + CW'(1);
          end
          state <= S_EMIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers: energy, cost window, trace operands, result
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      energy <= s_tdata[EUSE-1:0];
      win_l  <= win_m;
      win_m  <= win_r;
    end
    if (state == S_RD1) begin
      win_m <= rd_data;
    end
    if (state == S_COMP) begin
      win_r <= rd_data;
    end
    if (state == S_TM) begin
      tr_l <= rd_data;
    end
    if (state == S_TR) begin
      tr_m <= rd_data;
    end
    if (state == S_EMIT && out_free) begin
      m_tdata <= {(OUT_TDATA_W - SEAM_COL_W - SEAM_ROW_W)'(0),
                  SEAM_ROW_W'(trow), SEAM_COL_W'(tcol)};
      m_tlast <= (trow == hlast);
    end
  end

  // cost store
  scd_ram #(
    .WIDTH (COST_W),
    .DEPTH (1 << AW)
  ) u_cost_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr ({row, col}),
    .wdata (cost),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

`ifndef ASSERT_OFF
  a_state_onehot : assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_accept_starts_work : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !cfg_we) |=> (state == S_COMP || state == S_RD1))
    else $error("accepted pixel did not start cost work");

  a_col_in_frame : assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP) |-> (col <= wlast && row <= hlast))
    else $error("pixel position outside the frame");

  a_trace_row_range : assert property (@(posedge clk) disable iff (rst)
    (state == S_TL) |-> (trow != '0 && trow <= hlast))
    else $error("trace row out of range");

  a_frame_restart : assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && trow == hlast)
      |=> (state == S_IDLE && col == '0 && row == hlast && m_tvalid && m_tlast))
    else $error("frame did not restart after the bottom row");
`endif

endmodule

@@ hdl/scd_ram.sv @@
// ----------------------------------------------------------------------------
// scd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scd_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the seam cost accumulator and seam tracer.
// Pixel energies are streamed in frame by frame under random back-pressure
// and gaps. A cycle-free predictor follows every accepted pixel, builds the
// cumulative cost map and, on the top row's last pixel, traces the expected
// seam. Each seam row taken from the master stream is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import scd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;
  localparam int COST_W = 22;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  // energy patterns for frame content
  typedef enum int {
    EN_FULL,
    EN_TIES,
    EN_EXTREME,
    EN_MIXED
  } energy_mix_t;

  typedef struct packed {
    logic [SEAM_COL_W-1:0] column;
    logic [SEAM_ROW_W-1:0] row;
    logic                  last;
  } seam_step_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // pixel_energy[15:0]
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // seam_column[7:0], seam_row[13:8], zero fill [15:14]
  logic [OUT_TDATA_W-1:0] m_tdata;
  // seam_last
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // stimulus and expectation stores
  logic [IN_TDATA_W-1:0] pixel_q[$];
  seam_step_t            seam_q[$];

  // predictor state
  logic [COST_W-1:0]       cost_map [0:MAX_W*MAX_H-1];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int                      col_cnt;
  int                      row_cnt;
  logic [COST_W-1:0]       top_cost;
  int                      top_col;

  // bookkeeping
  int pixels_queued = 0;
  int pixels_taken = 0;
  int rows_checked = 0;
  int seams_seen = 0;
  int mismatches = 0;
  int send_gap = 0;
  int take_gap = 0;
  bit quiet = 1'b0;

  seam_cost_dp_and_trace DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int eff_width();
    int w;
    w = int'(width_reg);
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = int'(height_reg);
    if (h < 2) h = 2;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  function automatic void restart_frame();
    col_cnt = 0;
    row_cnt = eff_height() - 1;
    top_cost = '1;
    top_col = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = val[WIDTH_REG_W-1:0];
      restart_frame();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = val[HEIGHT_REG_W-1:0];
      restart_frame();
    end
  endfunction

  // cost of one pixel, best-top tracking and, on frame end, the seam
  function automatic void accumulate_pixel(logic [IN_TDATA_W-1:0] energy);
    int w, h, r, c, idx, tr;
    logic [COST_W-1:0] total, best, mid, lft, rgt, lo;
    seam_step_t step;
    w = eff_width();
    h = eff_height();
    r = row_cnt;
    c = col_cnt;
    if (r >= h) r = h - 1;
    if (c >= w) c = 0;
    total = COST_W'(energy[DEF_ENERGY_BITS-1:0]);
    // cheapest neighbour in the row below, clipped at the edges
    if (r < h - 1) begin
      best = cost_map[(r + 1) * MAX_W + c];
      if (c > 0 && cost_map[(r + 1) * MAX_W + c - 1] < best)
        best = cost_map[(r + 1) * MAX_W + c - 1];
      if (c < w - 1 && cost_map[(r + 1) * MAX_W + c + 1] < best)
        best = cost_map[(r + 1) * MAX_W + c + 1];
      total = total + best;
    end
    cost_map[r * MAX_W + c] = total;
    // top row minimum, ties to the rightmost column
    if (r == 0 && (c == 0 || total <= top_cost)) begin
      top_cost = total;
      top_col = c;
    end
    if (r == 0 && c == w - 1) begin
      // trace down, ties prefer left, then right, then middle
      idx = top_col;
      for (tr = 0; tr < h; tr++) begin
        if (tr > 0) begin
          mid = cost_map[tr * MAX_W + idx];
          if (idx > 0 && idx < w - 1) begin
            lft = cost_map[tr * MAX_W + idx - 1];
            rgt = cost_map[tr * MAX_W + idx + 1];
            lo = mid;
            if (lft < lo) lo = lft;
            if (rgt < lo) lo = rgt;
            if (lo == lft) idx--;
            else if (lo == rgt) idx++;
          end else if (idx > 0) begin
            if (cost_map[tr * MAX_W + idx - 1] <= mid) idx--;
          end else begin
            if (cost_map[tr * MAX_W + idx + 1] <= mid) idx++;
          end
        end
        step.column = idx[SEAM_COL_W-1:0];
        step.row = tr[SEAM_ROW_W-1:0];
        step.last = (tr == h - 1);
        seam_q.insert(seam_q.size(), step);
      end
      restart_frame();
    end else if (c == w - 1) begin
      col_cnt = 0;
      row_cnt = r - 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        accumulate_pixel(s_tdata);
        pixels_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 14) - 1;
          s_tvalid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= pixel_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // seam monitor
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    seam_step_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      // compare each transaction with the oldest expected seam row
      if (m_tvalid && m_tready) begin
        if (seam_q.size() == 0) begin
          report_mismatch("unexpected seam row", int'(m_tdata), -1);
        end else begin
          want = seam_q.pop_front();
          rows_checked++;
          if (m_tlast) seams_seen++;
          if (m_tdata[SEAM_COL_W-1:0] != want.column)
            report_mismatch("seam_column", int'(m_tdata[SEAM_COL_W-1:0]),
                            int'(want.column));
          if (m_tdata[SEAM_COL_W +: SEAM_ROW_W] != want.row)
            report_mismatch("seam_row", int'(m_tdata[SEAM_COL_W +: SEAM_ROW_W]),
                            int'(want.row));
          if (m_tlast != want.last)
            report_mismatch("seam_last", int'(m_tlast), int'(want.last));
          if (m_tdata[OUT_TDATA_W-1:SEAM_COL_W+SEAM_ROW_W] != '0)
            report_mismatch("tdata fill",
                            int'(m_tdata[OUT_TDATA_W-1:SEAM_COL_W+SEAM_ROW_W]), 0);
        end
      end
      // receiver stalls
      if (take_gap > 0) begin
        take_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        take_gap = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    apply_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pixel(logic [IN_TDATA_W-1:0] energy);
    pixel_q.insert(pixel_q.size(), energy);
    pixels_queued++;
  endtask

  function automatic logic [IN_TDATA_W-1:0] pick_energy(energy_mix_t mix);
    case (mix)
      EN_TIES:    return IN_TDATA_W'($urandom_range(0, 3));
      EN_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
      EN_MIXED:   return $urandom_range(0, 1) ? IN_TDATA_W'($urandom_range(0, 65535))
                                              : IN_TDATA_W'($urandom_range(0, 2));
      default:    return IN_TDATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_frame(int count, energy_mix_t mix);
    for (int i = 0; i < count; i++) push_pixel(pick_energy(mix));
  endtask

  // sender holds off until every pixel is taken and every seam row is back,
  // then a short pause covers a pixel still in flight
  task automatic drain_all();
    while (pixels_taken != pixels_queued || seam_q.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic random_size();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick != 1) write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(2, 16)));
    if (pick != 0) write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(2, 10)));
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int random_pixels;
    int pick;
    energy_mix_t mix;
    random_pixels = 0;
    width_reg = WIDTH_REG_W'(MAX_W);
    height_reg = HEIGHT_REG_W'(MAX_H);
    restart_frame();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // smallest frame, energy extremes; spare index must change nothing
    write_reg(REG_IMAGE_WIDTH, 9'd2);
    write_reg(REG_IMAGE_HEIGHT, 9'd2);
    write_reg(REG_SPARE_2, 9'h1FF);
    push_pixel(16'hFFFF);
    push_pixel(16'h0000);
    push_pixel(16'h0000);
    push_pixel(16'hFFFF);
    drain_all();

    // flat frame, every comparison a tie
    write_reg(REG_IMAGE_WIDTH, 9'd3);
    write_reg(REG_IMAGE_HEIGHT, 9'd3);
    for (int i = 0; i < 9; i++) push_pixel(16'd7);
    drain_all();

    // ties between left and right with a dearer middle
    write_reg(REG_IMAGE_WIDTH, 9'd4);
    write_reg(REG_SPARE_3, 9'h0AA);
    push_pixel(16'd0); push_pixel(16'd9); push_pixel(16'd0); push_pixel(16'd9);
    push_pixel(16'd5); push_pixel(16'd5); push_pixel(16'd5); push_pixel(16'd5);
    push_pixel(16'd1); push_pixel(16'hFFFF); push_pixel(16'd1); push_pixel(16'd1);
    drain_all();

    // register extremes and clamping: narrowest and tallest
    write_reg(REG_IMAGE_WIDTH, 9'd0);
    write_reg(REG_IMAGE_HEIGHT, 9'd127);
    push_frame(2 * MAX_H, EN_MIXED);
    drain_all();

    // clamp above the width limit, frame cut short by a register write
    write_reg(REG_IMAGE_WIDTH, 9'd257);
    write_reg(REG_IMAGE_HEIGHT, 9'd0);
    push_frame(40, EN_FULL);
    drain_all();
    write_reg(REG_IMAGE_WIDTH, 9'd1);
    write_reg(REG_IMAGE_HEIGHT, 9'd65);
    write_reg(REG_IMAGE_HEIGHT, 9'd0);
    push_frame(4, EN_EXTREME);
    drain_all();

    // random frames of small size, mostly back to back
    random_size();
    while (random_pixels < 225) begin
      if (random_pixels > 170) quiet = 1'b1;
      mix = energy_mix_t'($urandom_range(0, 3));
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        // frame abandoned part way, then restarted by a new size
        pick = $urandom_range(1, eff_width() * eff_height() - 1);
        push_frame(pick, mix);
        random_pixels += pick;
        drain_all();
        random_size();
      end else begin
        if (pick <= 2) begin
          drain_all();
          random_size();
        end
        pick = eff_width() * eff_height();
        push_frame(pick, mix);
        random_pixels += pick;
      end
    end

    drain_all();
    repeat (40) @(posedge clk);
    $display("pixels sent: %0d, seams traced: %0d, seam rows compared: %0d",
             pixels_taken, seams_seen, rows_checked);
    $display("sizes from 2x2 up to 256 wide and 64 tall, incl. clamped, cut and tied frames");
    if (mismatches == 0 && seam_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("timeout with %0d seam rows outstanding", seam_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
hdl/scd_pkg.sv
hdl/scd_ram.sv
hdl/seam_cost_dp_and_trace.sv
tb/sv/tb.sv
